// File: sv/fms_pkg.sv
// Package with the sizes, codes and control types of the fingerprint similarity block.
`default_nettype none

package fms_pkg;

    localparam int NUM_BINS    = 128;
    localparam int COUNT_WIDTH = 16;

    localparam int FP_W      = 7;
    localparam int OP_W      = 2;
    localparam int SIM_W     = 15;
    localparam int OUT_CNT_W = 17;

    localparam int ADDR_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int IDX_W   = (ADDR_W > FP_W) ? ADDR_W : FP_W;
    localparam int CNT_W   = COUNT_WIDTH;
    localparam int MATCH_W = COUNT_WIDTH + 1;
    localparam int TOT_W   = COUNT_WIDTH + 1;
    localparam int PROD_W  = MATCH_W + SIM_W;
    localparam int DCNT_W  = $clog2(PROD_W);
    localparam int EXT_W   = (MATCH_W > OUT_CNT_W) ? MATCH_W : OUT_CNT_W;

    localparam logic [CNT_W-1:0]     CNT_MAX   = '1;
    localparam logic [MATCH_W-1:0]   MATCH_MAX = {CNT_MAX, 1'b0};
    localparam logic [EXT_W-1:0]     OUT_MAX   = EXT_W'({OUT_CNT_W{1'b1}});
    localparam logic [SIM_W-1:0]     SIM_FULL  = SIM_W'(25600);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_PROBE  = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic update;
        logic mul;
        logic div_step;
        logic emit;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/fms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/fms_ctrl.sv
// Controller state machine that sequences items, the division and the histogram clear.
`default_nettype none

module fms_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [fms_pkg::OP_W-1:0] i_opcode,
    output logic                       o_stall,
    input  wire fms_pkg::t_sts         i_sts,
    output fms_pkg::t_cmd              o_cmd
);
    import fms_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_comb begin
        o_stall = (r_state != ST_IDLE) || ((i_opcode == OP_FINISH) && !i_sts.out_free);
        accept  = i_valid && !o_stall;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_LOAD, OP_PROBE: n_state = ST_UPDATE;
                        OP_FINISH:         n_state = ST_MUL;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UPDATE: n_state = ST_IDLE;
            ST_MUL:    n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT:   n_state = ST_CLEAR;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.take     = (r_state == ST_IDLE) && accept;
        o_cmd.update   = (r_state == ST_UPDATE);
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.emit     = (r_state == ST_EMIT);
        o_cmd.clr_step = (r_state == ST_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/fms_dp.sv
// Datapath with the histogram memory, item counters, divider and output register.
`default_nettype none

module fms_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fms_pkg::t_cmd               i_cmd,
    output fms_pkg::t_sts                    o_sts,
    input  wire logic [fms_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [fms_pkg::FP_W-1:0]    i_fingerprint,
    input  wire logic                        i_stall,
    output logic                             o_valid,
    output logic [fms_pkg::SIM_W-1:0]        o_similarity_q8,
    output logic [fms_pkg::OUT_CNT_W-1:0]    o_matched_count,
    output logic [fms_pkg::OUT_CNT_W-1:0]    o_total_count,
    output logic                             o_empty_set
);
    import fms_pkg::*;

    logic [CNT_W-1:0]   r_ref_tot;
    logic [CNT_W-1:0]   r_cand_tot;
    logic [MATCH_W-1:0] r_match;
    logic [MATCH_W-1:0] r_match_snap;
    logic [TOT_W-1:0]   r_div_tot;
    logic [PROD_W-1:0]  r_quo;
    logic [TOT_W-1:0]   r_rem;
    logic [DCNT_W-1:0]  r_div_cnt;
    logic [ADDR_W-1:0]  r_clr_idx;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_in_tab;
    logic               r_is_probe;
    logic               r_out_valid;

    logic [IDX_W-1:0]   fp_wide;
    logic               in_tab;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CNT_W-1:0]   rd_data;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [TOT_W:0]     rem_sh;
    logic [TOT_W:0]     rem_diff;
    logic               q_bit;
    logic [EXT_W-1:0]   match_ext;
    logic [EXT_W-1:0]   tot_ext;
    logic               is_finish;

    always_comb begin
        fp_wide   = IDX_W'(i_fingerprint);
        in_tab    = {1'b0, fp_wide} < (IDX_W + 1)'(NUM_BINS);
        rd_addr   = fp_wide[ADDR_W-1:0];
        is_finish = (i_opcode == OP_FINISH);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (i_cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
        end else if (i_cmd.update && r_in_tab) begin
            if (r_is_probe) begin
                ram_we    = (rd_data != '0);
                ram_wdata = rd_data - CNT_W'(1);
            end else begin
                ram_we    = 1'b1;
                ram_wdata = (rd_data == CNT_MAX) ? rd_data : rd_data + CNT_W'(1);
            end
        end
    end

    fms_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.take),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        rem_sh   = {r_rem, r_quo[PROD_W-1]};
        rem_diff = rem_sh - {1'b0, r_div_tot};
        q_bit    = (rem_sh >= {1'b0, r_div_tot});
    end

    always_comb begin
        match_ext = EXT_W'(r_match_snap);
        tot_ext   = EXT_W'(r_div_tot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_tot   <= '0;
            r_cand_tot  <= '0;
            r_match     <= '0;
            r_clr_idx   <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take && is_finish) begin
                r_ref_tot  <= '0;
                r_cand_tot <= '0;
                r_match    <= '0;
            end
            if (i_cmd.update) begin
                if (r_is_probe) begin
                    if (r_cand_tot != CNT_MAX) begin
                        r_cand_tot <= r_cand_tot + CNT_W'(1);
                    end
                    if (r_in_tab && (rd_data != '0)) begin
                        r_match <= (r_match > MATCH_MAX - MATCH_W'(2)) ?
                                   MATCH_MAX : r_match + MATCH_W'(2);
                    end
                end else if (r_ref_tot != CNT_MAX) begin
                    r_ref_tot <= r_ref_tot + CNT_W'(1);
                end
            end
            if (i_cmd.mul) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DCNT_W'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= o_sts.clr_last ? '0 : r_clr_idx + ADDR_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_addr     <= rd_addr;
            r_in_tab   <= in_tab;
            r_is_probe <= (i_opcode == OP_PROBE);
            if (is_finish) begin
                r_match_snap <= r_match;
                r_div_tot    <= TOT_W'(r_ref_tot) + TOT_W'(r_cand_tot);
            end
        end
        if (i_cmd.mul) begin
            r_quo <= PROD_W'(r_match_snap) * PROD_W'(SIM_FULL);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PROD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
        end
        if (i_cmd.emit) begin
            o_empty_set     <= (r_div_tot == '0);
            if (r_div_tot == '0) begin
                o_similarity_q8 <= '0;
            end else if (r_quo > PROD_W'(SIM_FULL)) begin
                o_similarity_q8 <= SIM_FULL;
            end else begin
                o_similarity_q8 <= r_quo[SIM_W-1:0];
            end
            o_matched_count <= (match_ext > OUT_MAX) ? OUT_MAX[OUT_CNT_W-1:0]
                                                     : match_ext[OUT_CNT_W-1:0];
            o_total_count   <= (tot_ext > OUT_MAX) ? OUT_MAX[OUT_CNT_W-1:0]
                                                   : tot_ext[OUT_CNT_W-1:0];
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_idx == ADDR_W'(NUM_BINS - 1));
        o_sts.div_last = (r_div_cnt == DCNT_W'(PROD_W - 1));
        o_sts.out_free = !r_out_valid || !i_stall;
        o_valid        = r_out_valid;
    end

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid)
        else $error("Result produced while the output register still holds an item.");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && is_finish) |=>
            (r_ref_tot == '0 && r_cand_tot == '0 && r_match == '0))
        else $error("Counters not cleared after a finish item.");

    a_no_zero_decrement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_is_probe && ram_we) |-> (rd_data != '0))
        else $error("Probe decremented an empty bin.");

    a_div_in_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> $past(i_cmd.div_step))
        else $error("Result emitted without a completed division.");

endmodule

`default_nettype wire

// File: sv/fingerprint_multiset_similarity.sv
// Top level of the multiset Dice similarity block for fingerprint streams.
//
//   Channel   Handshake                  Payload
//   input     i_valid / o_stall          i_opcode, i_fingerprint
//   output    o_valid / i_stall          o_similarity_q8, o_matched_count,
//                                        o_total_count, o_empty_set
//
// A reference or candidate item is a histogram memory read, then the write back.
// An unused opcode is taken and dropped. A finish item runs a multiply, a one-bit-per-cycle
// restoring divider, the result write, then a histogram clear of one bin a cycle.
// After reset the histogram is cleared before the first item is taken.
// A waiting result stalls only the next finish item; other items keep flowing.
`default_nettype none

module fingerprint_multiset_similarity (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [fms_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [fms_pkg::FP_W-1:0]     i_fingerprint,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [fms_pkg::SIM_W-1:0]         o_similarity_q8,
    output logic [fms_pkg::OUT_CNT_W-1:0]     o_matched_count,
    output logic [fms_pkg::OUT_CNT_W-1:0]     o_total_count,
    output logic                              o_empty_set
);
    import fms_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    fms_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_fingerprint   (i_fingerprint),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_similarity_q8 (o_similarity_q8),
        .o_matched_count (o_matched_count),
        .o_total_count   (o_total_count),
        .o_empty_set     (o_empty_set)
    );

endmodule

`default_nettype wire
